@@ rtl/stme_pkg.sv @@
// ----------------------------------------------------------------------------
// Seed table package
// Shared constants and request/status codes for the seed table.
// ----------------------------------------------------------------------------
package stme_pkg;

    localparam int TableDepthDefault = 64;
    localparam int PosBitsDefault    = 16;
    localparam int LEN_BITS          = 6;
    localparam int EN_BITS           = 16;
    localparam int CNT_BITS          = 7;
    localparam int SEQ_BITS          = 17;
    localparam int WIN_BITS          = 16;

    localparam logic signed [EN_BITS-1:0] ENERGY_INF = 16'sd32767;

    typedef enum logic [1:0]
    {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_COUNT  = 2'd2,
        REQ_NEXT   = 2'd3
    } req_t;

    typedef enum logic [1:0]
    {
        ST_NEW     = 2'd0,
        ST_REPLACE = 2'd1,
        ST_KEPT    = 2'd2,
        ST_FULL    = 2'd3
    } ins_status_t;

    localparam logic [0:0] ADDR_SEQ1 = 1'b0;
    localparam logic [0:0] ADDR_SEQ2 = 1'b1;

endpackage

@@ rtl/seed_table_min_energy.sv @@
// ----------------------------------------------------------------------------
// Seed table with minimum-energy replacement
// Stores seeds in one synchronous memory and answers insert, lookup, count
// and next requests by scanning the table one entry per cycle.
// ----------------------------------------------------------------------------
// Every request type takes a full scan of the table before its result is valid;
// the memory scan reads one entry per cycle.
// A new request is taken only in the idle state, after the previous result is
// loaded; it is taken while that result waits in the output register.
// Reset: valid bits clear at once, lengths reset to 65536; no clearing pass.
module seed_table_min_energy
    import stme_pkg::*;
#(
    parameter int TABLE_DEPTH = TableDepthDefault,
    parameter int POS_BITS    = PosBitsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: req_type[1:0], key_pos1, key_pos2, new_len1, new_len2, new_energy,
    // win1_lo, win1_hi, win2_lo, win2_hi (from bit 0 up), zero padded
    input  logic [((2+2*POS_BITS+2*LEN_BITS+EN_BITS+4*WIN_BITS+7)/8)*8-1:0] s_tdata,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: hit, seed_energy, seed_len1, seed_len2, inside_count, next_pos1,
    // next_pos2, insert_status (from bit 0 up), zero padded
    output logic [((1+EN_BITS+2*LEN_BITS+CNT_BITS+2*POS_BITS+2+7)/8)*8-1:0] m_tdata
);

    localparam int IDX_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SC_BITS  = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_W    = 1 + EN_BITS + 2*LEN_BITS + CNT_BITS + 2*POS_BITS + 2;
    localparam int OUT_TW   = ((OUT_W + 7) / 8) * 8;
    localparam int IN_W     = 2 + 2*POS_BITS + 2*LEN_BITS + EN_BITS + 4*WIN_BITS;
    localparam int IN_TW    = ((IN_W + 7) / 8) * 8;
    localparam int WIN_OFS  = 2 + 2*POS_BITS + 2*LEN_BITS + EN_BITS;
    localparam int CMP_W    = ((POS_BITS > WIN_BITS) ? POS_BITS : WIN_BITS) + 2;
    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

    typedef struct packed
    {
        logic [POS_BITS-1:0] pos1;
        logic [POS_BITS-1:0] pos2;
        logic [LEN_BITS-1:0] span1;
        logic [LEN_BITS-1:0] span2;
        logic [EN_BITS-1:0]  energy;
    } entry_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    // Configuration registers.
    logic [SEQ_BITS-1:0] seq1_reg, seq2_reg;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq1_reg <= SEQ_BITS'(65536);
            seq2_reg <= SEQ_BITS'(65536);
        end
        else if (cfg_wr && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[2])
                ADDR_SEQ1: seq1_reg <= pwdata[SEQ_BITS-1:0];
                ADDR_SEQ2: seq2_reg <= pwdata[SEQ_BITS-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            ADDR_SEQ1: prdata = {{(32-SEQ_BITS){1'b0}}, seq1_reg};
            ADDR_SEQ2: prdata = {{(32-SEQ_BITS){1'b0}}, seq2_reg};
            default:   prdata = '0;
        endcase
    end

    // Request fields.
    logic [IN_TW-1:0]    in_bus;
    logic [WIN_BITS-1:0] in_w1hi, in_w2hi;
    logic [SEQ_BITS-1:0] lim1, lim2;
    assign in_bus  = s_tdata[IN_TW-1:0];
    assign in_w1hi = in_bus[WIN_OFS+WIN_BITS +: WIN_BITS];
    assign in_w2hi = in_bus[WIN_OFS+3*WIN_BITS +: WIN_BITS];
    // Upper window limits for next; a zero length wraps to the largest value.
    assign lim1    = seq1_reg - SEQ_BITS'(1);
    assign lim2    = seq2_reg - SEQ_BITS'(1);

    // Captured request.
    logic [1:0]          req_reg;
    logic [POS_BITS-1:0] k1_reg, k2_reg;
    logic [LEN_BITS-1:0] nl1_reg, nl2_reg;
    logic [EN_BITS-1:0]  ne_reg;
    logic [WIN_BITS-1:0] w1lo_reg, w1hi_reg, w2lo_reg, w2hi_reg;
    logic [SEQ_BITS-1:0] h1_reg, h2_reg;

    // Memory and valid bits.
    entry_t              mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    entry_t              rd_q;
    logic                rd_v_reg;
    logic [IDX_BITS-1:0] rd_idx_reg;
    logic                mem_we;
    logic [IDX_BITS-1:0] mem_wa;
    entry_t              mem_wd;

    // Scan state.
    state_t              state_reg;
    logic [SC_BITS-1:0]  addr_reg;
    logic                chk_reg;
    logic                found_reg;
    logic [IDX_BITS-1:0] found_idx_reg;
    entry_t              found_ent_reg;
    logic                free_reg;
    logic [IDX_BITS-1:0] free_idx_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                nhit_reg;
    logic [POS_BITS-1:0] np1_reg, np2_reg;
    logic                cand_reg;
    logic [POS_BITS-1:0] c1_reg, c2_reg;
    logic                m_valid_reg;
    logic [OUT_TW-1:0]   m_data_reg;
    logic                have_cur;
    logic                out_load;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_q <= mem[addr_reg[IDX_BITS-1:0]];
    end

    // Per-entry checks on the registered read data.
    logic [CMP_W-1:0] p1_x, p2_x, e1_x, e2_x;
    logic key_eq, in_cnt, in_nxt, after_cur, below_best;
    always_comb
    begin
        p1_x = CMP_W'(rd_q.pos1);
        p2_x = CMP_W'(rd_q.pos2);
        // Right end plus one, so a zero span needs no signed compare.
        e1_x = p1_x + CMP_W'(rd_q.span1);
        e2_x = p2_x + CMP_W'(rd_q.span2);
        key_eq = rd_v_reg && rd_q.pos1 == k1_reg && rd_q.pos2 == k2_reg;
        in_cnt = rd_v_reg
              && p1_x >= CMP_W'(w1lo_reg)
              && e1_x <= CMP_W'(w1hi_reg) + CMP_W'(1)
              && p2_x >= CMP_W'(w2lo_reg)
              && e2_x <= CMP_W'(w2hi_reg) + CMP_W'(1);
        in_nxt = rd_v_reg
              && p1_x >= CMP_W'(w1lo_reg)
              && p1_x <= CMP_W'(h1_reg)
              && p2_x >= CMP_W'(w2lo_reg)
              && p2_x <= CMP_W'(h2_reg);
        after_cur  = (k1_reg < rd_q.pos1) || (k1_reg == rd_q.pos1 && k2_reg < rd_q.pos2);
        below_best = !nhit_reg || (rd_q.pos1 < np1_reg)
                  || (rd_q.pos1 == np1_reg && rd_q.pos2 < np2_reg);
    end

    assign have_cur = found_reg;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_tready);

    // Write port: insert commits when its result is loaded.
    logic ins_replace, ins_new;
    always_comb
    begin
        ins_replace = found_reg && $signed(ne_reg) < $signed(found_ent_reg.energy);
        ins_new     = !found_reg && free_reg;
        mem_we = out_load && req_reg == REQ_INSERT
              && (ins_replace || ins_new);
        mem_wa = found_reg ? found_idx_reg : free_idx_reg;
        mem_wd.pos1   = k1_reg;
        mem_wd.pos2   = k2_reg;
        mem_wd.span1  = nl1_reg;
        mem_wd.span2  = nl2_reg;
        mem_wd.energy = ne_reg;
    end

    // Result word.
    logic [OUT_W-1:0] res;
    logic [1:0]       st_code;
    always_comb
    begin
        st_code = 2'(ST_NEW);
        if (found_reg)
            st_code = ins_replace ? 2'(ST_REPLACE) : 2'(ST_KEPT);
        else if (!free_reg)
            st_code = 2'(ST_FULL);
        res = '0;
        res[EN_BITS:1] = ENERGY_INF;
        unique case (req_reg)
            REQ_INSERT:
                res[OUT_W-1 -: 2] = st_code;
            REQ_LOOKUP:
                if (found_reg)
                begin
                    res[0] = 1'b1;
                    res[EN_BITS:1] = found_ent_reg.energy;
                    res[EN_BITS+LEN_BITS:EN_BITS+1] = found_ent_reg.span1;
                    res[EN_BITS+2*LEN_BITS:EN_BITS+LEN_BITS+1] = found_ent_reg.span2;
                end
            REQ_COUNT:
                res[EN_BITS+2*LEN_BITS+CNT_BITS -: CNT_BITS] = cnt_reg;
            REQ_NEXT:
            begin
                // Without the current key the search starts from the smallest key.
                res[0] = have_cur ? nhit_reg : cand_reg;
                res[EN_BITS+2*LEN_BITS+CNT_BITS+POS_BITS -: POS_BITS] =
                    have_cur ? np1_reg : c1_reg;
                res[EN_BITS+2*LEN_BITS+CNT_BITS+2*POS_BITS -: POS_BITS] =
                    have_cur ? np2_reg : c2_reg;
            end
            default: ;
        endcase
    end

    // Sequencer: one pass finds the key, the free slot and the count, and
    // tracks both the smallest key after the current one and the overall
    // smallest, so next needs no second pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
            addr_reg      <= '0;
            chk_reg       <= 1'b0;
            rd_v_reg      <= 1'b0;
            rd_idx_reg    <= '0;
            cand_reg      <= 1'b0;
            c1_reg        <= '0;
            c2_reg        <= '0;
            req_reg       <= '0;
            k1_reg        <= '0;
            k2_reg        <= '0;
            nl1_reg       <= '0;
            nl2_reg       <= '0;
            ne_reg        <= '0;
            w1lo_reg      <= '0;
            w1hi_reg      <= '0;
            w2lo_reg      <= '0;
            w2hi_reg      <= '0;
            h1_reg        <= '0;
            h2_reg        <= '0;
            found_reg     <= 1'b0;
            found_idx_reg <= '0;
            found_ent_reg <= '0;
            free_reg      <= 1'b0;
            free_idx_reg  <= '0;
            cnt_reg       <= '0;
            nhit_reg      <= 1'b0;
            np1_reg       <= '0;
            np2_reg       <= '0;
        end
        else
        begin
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (s_tvalid)
                    begin
                        req_reg  <= in_bus[1:0];
                        k1_reg   <= in_bus[2 +: POS_BITS];
                        k2_reg   <= in_bus[2+POS_BITS +: POS_BITS];
                        nl1_reg  <= in_bus[2+2*POS_BITS +: LEN_BITS];
                        nl2_reg  <= in_bus[2+2*POS_BITS+LEN_BITS +: LEN_BITS];
                        ne_reg   <= in_bus[2+2*POS_BITS+2*LEN_BITS +: EN_BITS];
                        w1lo_reg <= in_bus[WIN_OFS +: WIN_BITS];
                        w1hi_reg <= in_w1hi;
                        w2lo_reg <= in_bus[WIN_OFS+2*WIN_BITS +: WIN_BITS];
                        w2hi_reg <= in_w2hi;
                        h1_reg <= (SEQ_BITS'(in_w1hi) < lim1) ? SEQ_BITS'(in_w1hi) : lim1;
                        h2_reg <= (SEQ_BITS'(in_w2hi) < lim2) ? SEQ_BITS'(in_w2hi) : lim2;
                        addr_reg  <= '0;
                        chk_reg   <= 1'b0;
                        cand_reg  <= 1'b0;
                        c1_reg    <= '0;
                        c2_reg    <= '0;
                        found_reg <= 1'b0;
                        free_reg  <= 1'b0;
                        cnt_reg   <= '0;
                        nhit_reg  <= 1'b0;
                        np1_reg   <= '0;
                        np2_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                S_SCAN:
                begin
                    // Issue read of addr_reg; examine the previous one.
                    rd_v_reg   <= (addr_reg < SC_BITS'(TABLE_DEPTH))
                               && valid_reg[addr_reg[IDX_BITS-1:0]];
                    rd_idx_reg <= addr_reg[IDX_BITS-1:0];
                    chk_reg    <= addr_reg < SC_BITS'(TABLE_DEPTH);
                    if (addr_reg < SC_BITS'(TABLE_DEPTH))
                        addr_reg <= addr_reg + 1'b1;
                    if (chk_reg)
                    begin
                        if (key_eq && !found_reg)
                        begin
                            found_reg     <= 1'b1;
                            found_idx_reg <= rd_idx_reg;
                            found_ent_reg <= rd_q;
                        end
                        if (!rd_v_reg && !free_reg)
                        begin
                            free_reg     <= 1'b1;
                            free_idx_reg <= rd_idx_reg;
                        end
                        if (in_cnt && cnt_reg != CNT_MAX)
                            cnt_reg <= cnt_reg + 1'b1;
                        // Smallest candidate after the key, and overall smallest.
                        if (in_nxt && after_cur && below_best)
                        begin
                            nhit_reg <= 1'b1;
                            np1_reg  <= rd_q.pos1;
                            np2_reg  <= rd_q.pos2;
                        end
                        if (in_nxt && (!cand_reg || rd_q.pos1 < c1_reg
                            || (rd_q.pos1 == c1_reg && rd_q.pos2 < c2_reg)))
                        begin
                            cand_reg <= 1'b1;
                            c1_reg   <= rd_q.pos1;
                            c2_reg   <= rd_q.pos2;
                        end
                    end
                    if (!chk_reg && addr_reg == SC_BITS'(TABLE_DEPTH))
                        state_reg <= S_DONE;
                end
                S_DONE:
                    if (out_load)
                    begin
                        m_data_reg <= OUT_TW'(res);
                        if (mem_we && ins_new)
                            valid_reg[free_idx_reg] <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Checks.
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == S_DONE) else $error("write outside commit");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> state_reg == S_SCAN) else $error("scan not started");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !free_reg && !found_reg) |-> !mem_we)
        else $error("write into full table");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while waiting");

endmodule

@@ bench/seed_table_min_energy_tb.sv @@
// ----------------------------------------------------------------------------
// Seed table testbench
// Sends insert, lookup, count and next requests over the request stream. A
// scoreboard keeps its own copy of the seed table, predicts each result and
// compares it field by field with the result stream. Lengths are programmed
// over APB between phases, and the handshakes idle at random in some phases.
// ----------------------------------------------------------------------------
module seed_table_min_energy_tb
    import stme_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int Depth = 64;

    typedef struct packed
    {
        logic [1:0]  st;
        logic [15:0] np2;
        logic [15:0] np1;
        logic [6:0]  cnt;
        logic [5:0]  len2;
        logic [5:0]  len1;
        logic [15:0] energy;
        logic        hit;
    } seed_result_t;

    typedef struct packed
    {
        logic [15:0] w2hi;
        logic [15:0] w2lo;
        logic [15:0] w1hi;
        logic [15:0] w1lo;
        logic [15:0] energy;
        logic [5:0]  len2;
        logic [5:0]  len1;
        logic [15:0] key2;
        logic [15:0] key1;
        logic [1:0]  req;
    } seed_request_t;

    // Scoreboard: private copy of the seed table and the queue of predictions.
    class seed_scoreboard;
        bit          valid[Depth];
        bit   [15:0] pos1[Depth];
        bit   [15:0] pos2[Depth];
        bit   [5:0]  span1[Depth];
        bit   [5:0]  span2[Depth];
        bit signed [15:0] en[Depth];
        bit   [16:0] len_seq1;
        bit   [16:0] len_seq2;
        seed_result_t pending[$];
        int errors;

        function new();
            len_seq1 = 17'd65536;
            len_seq2 = 17'd65536;
            errors = 0;
            foreach (valid[i]) valid[i] = 0;
        endfunction

        function int find_slot(bit [15:0] k1, bit [15:0] k2);
            for (int i = 0; i < Depth; i++)
                if (valid[i] && pos1[i] == k1 && pos2[i] == k2)
                    return i;
            return -1;
        endfunction

        // Predict the result of an accepted request and update the table.
        function void note_request(seed_request_t rq);
            seed_result_t r;
            int s;
            int e1;
            int e2;
            bit [16:0] m1;
            bit [16:0] m2;
            bit [16:0] h1;
            bit [16:0] h2;
            bit have_cur;
            r = '0;
            r.energy = ENERGY_INF;
            case (req_t'(rq.req))
                REQ_INSERT:
                begin
                    s = find_slot(rq.key1, rq.key2);
                    if (s >= 0)
                    begin
                        if ($signed(rq.energy) < en[s])
                        begin
                            span1[s] = rq.len1;
                            span2[s] = rq.len2;
                            en[s] = rq.energy;
                            r.st = ST_REPLACE;
                        end
                        else
                            r.st = ST_KEPT;
                    end
                    else
                    begin
                        r.st = ST_FULL;
                        for (int i = 0; i < Depth; i++)
                        begin
                            if (!valid[i])
                            begin
                                valid[i] = 1;
                                pos1[i] = rq.key1;
                                pos2[i] = rq.key2;
                                span1[i] = rq.len1;
                                span2[i] = rq.len2;
                                en[i] = rq.energy;
                                r.st = ST_NEW;
                                break;
                            end
                        end
                    end
                end
                REQ_LOOKUP:
                begin
                    s = find_slot(rq.key1, rq.key2);
                    if (s >= 0)
                    begin
                        r.hit = 1;
                        r.energy = en[s];
                        r.len1 = span1[s];
                        r.len2 = span2[s];
                    end
                end
                REQ_COUNT:
                begin
                    for (int i = 0; i < Depth; i++)
                    begin
                        if (!valid[i])
                            continue;
                        // A zero span puts the right end one left of the start.
                        e1 = int'(pos1[i]) + int'(span1[i]) - 1;
                        e2 = int'(pos2[i]) + int'(span2[i]) - 1;
                        if (pos1[i] >= rq.w1lo && e1 <= int'(rq.w1hi) &&
                            pos2[i] >= rq.w2lo && e2 <= int'(rq.w2hi) && r.cnt < 127)
                            r.cnt++;
                    end
                end
                default:
                begin
                    m1 = len_seq1 - 17'd1;
                    m2 = len_seq2 - 17'd1;
                    h1 = ({1'b0, rq.w1hi} < m1) ? {1'b0, rq.w1hi} : m1;
                    h2 = ({1'b0, rq.w2hi} < m2) ? {1'b0, rq.w2hi} : m2;
                    have_cur = find_slot(rq.key1, rq.key2) >= 0;
                    for (int i = 0; i < Depth; i++)
                    begin
                        if (!valid[i])
                            continue;
                        if (pos1[i] < rq.w1lo || pos1[i] > h1 ||
                            pos2[i] < rq.w2lo || pos2[i] > h2)
                            continue;
                        if (have_cur && !(rq.key1 < pos1[i] ||
                            (rq.key1 == pos1[i] && rq.key2 < pos2[i])))
                            continue;
                        if (!r.hit || pos1[i] < r.np1 ||
                            (pos1[i] == r.np1 && pos2[i] < r.np2))
                        begin
                            r.hit = 1;
                            r.np1 = pos1[i];
                            r.np2 = pos2[i];
                        end
                    end
                end
            endcase
            pending = {pending, r};
        endfunction

        // Compare one transferred result with the oldest prediction.
        function void check_result(seed_result_t got);
            seed_result_t w;
            if (pending.size() == 0)
            begin
                $error("result with no prediction waiting: %h", got);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.hit !== w.hit)
            begin
                $error("hit: expected %0d, actual %0d", w.hit, got.hit);
                errors++;
            end
            if (got.energy !== w.energy)
            begin
                $error("seed_energy: expected %0d, actual %0d",
                       $signed(w.energy), $signed(got.energy));
                errors++;
            end
            if (got.len1 !== w.len1)
            begin
                $error("seed_len1: expected %0d, actual %0d", w.len1, got.len1);
                errors++;
            end
            if (got.len2 !== w.len2)
            begin
                $error("seed_len2: expected %0d, actual %0d", w.len2, got.len2);
                errors++;
            end
            if (got.cnt !== w.cnt)
            begin
                $error("inside_count: expected %0d, actual %0d", w.cnt, got.cnt);
                errors++;
            end
            if (got.np1 !== w.np1)
            begin
                $error("next_pos1: expected %0d, actual %0d", w.np1, got.np1);
                errors++;
            end
            if (got.np2 !== w.np2)
            begin
                $error("next_pos2: expected %0d, actual %0d", w.np2, got.np2);
                errors++;
            end
            if (got.st !== w.st)
            begin
                $error("insert_status: expected %0d, actual %0d", w.st, got.st);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    // tdata: req_type, key_pos1, key_pos2, new_len1, new_len2, new_energy,
    // win1_lo, win1_hi, win2_lo, win2_hi (from bit 0 up), zero padded
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // tdata: hit, seed_energy, seed_len1, seed_len2, inside_count, next_pos1,
    // next_pos2, insert_status (from bit 0 up), zero padded
    logic [71:0]  m_tdata;

    seed_scoreboard seed_sb;
    int send_idle_pct;
    int recv_stall_pct;

    seed_table_min_energy dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Note every accepted request and check every transferred result.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            seed_sb.note_request(seed_request_t'(s_tdata[125:0]));
        if (rst_n && m_tvalid && m_tready)
            seed_sb.check_result(seed_result_t'(m_tdata[69:0]));
    end

    // Receiver back pressure.
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic send_request(seed_request_t rq);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {2'd0, rq};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_fields(logic [1:0] req, logic [15:0] k1, logic [15:0] k2,
                               logic [5:0] l1, logic [5:0] l2, logic [15:0] e,
                               logic [15:0] a, logic [15:0] b,
                               logic [15:0] c, logic [15:0] d);
        seed_request_t rq;
        rq = '{w2hi: d, w2lo: c, w1hi: b, w1lo: a, energy: e, len2: l2, len1: l1,
               key2: k2, key1: k1, req: req};
        send_request(rq);
    endtask

    // Wait for every prediction to be met, then let the block settle.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (seed_sb.pending.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_lengths(logic [16:0] l1, logic [16:0] l2);
        apb_write({ADDR_SEQ1, 2'b00}, {15'd0, l1});
        apb_write({ADDR_SEQ2, 2'b00}, {15'd0, l2});
        seed_sb.len_seq1 = l1;
        seed_sb.len_seq2 = l2;
    endtask

    function automatic logic [15:0] rand_pos();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return 16'($urandom_range(15));
        else if (pick < 70)
            return 16'(65535 - $urandom_range(3));
        else
            return 16'($urandom);
    endfunction

    function automatic seed_request_t rand_request();
        seed_request_t rq;
        rq.req = 2'($urandom_range(3));
        rq.key1 = rand_pos();
        rq.key2 = rand_pos();
        rq.len1 = 6'($urandom_range(63));
        rq.len2 = 6'($urandom_range(63));
        rq.energy = 16'($urandom);
        if ($urandom_range(1))
        begin
            rq.w1lo = 16'($urandom);
            rq.w1hi = 16'($urandom);
            rq.w2lo = 16'($urandom);
            rq.w2hi = 16'($urandom);
        end
        else
        begin
            // Windows anchored near zero so that small keys fall inside.
            rq.w1lo = 16'($urandom_range(8));
            rq.w1hi = ($urandom_range(1)) ? 16'($urandom_range(80)) : 16'hFFFF;
            rq.w2lo = 16'($urandom_range(8));
            rq.w2hi = ($urandom_range(1)) ? 16'($urandom_range(80)) : 16'hFFFF;
        end
        return rq;
    endfunction

    initial
    begin
        int stall_set[5];
        int idle_set[5];
        seed_sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        idle_set = '{0, 62, 0, 22, 0};
        stall_set = '{0, 0, 62, 22, 0};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed requests: empty table, replacement rules, extremes.
        send_fields(REQ_NEXT, 16'd0, 16'd0, 6'd0, 6'd0, 16'd0,
                    16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        send_fields(REQ_LOOKUP, 16'd0, 16'd0, 6'd0, 6'd0, 16'd0,
                    16'd0, 16'd0, 16'd0, 16'd0);
        send_fields(REQ_INSERT, 16'd0, 16'd0, 6'd1, 6'd1, 16'd0,
                    16'd0, 16'd0, 16'd0, 16'd0);
        send_fields(REQ_INSERT, 16'd0, 16'd0, 6'd63, 6'd63, 16'h8000,
                    16'd0, 16'd0, 16'd0, 16'd0);
        send_fields(REQ_INSERT, 16'd0, 16'd0, 6'd5, 6'd5, 16'h8000,
                    16'd0, 16'd0, 16'd0, 16'd0);
        send_fields(REQ_INSERT, 16'd0, 16'd0, 6'd7, 6'd7, 16'h7FFF,
                    16'd0, 16'd0, 16'd0, 16'd0);
        send_fields(REQ_LOOKUP, 16'd0, 16'd0, 6'd0, 6'd0, 16'd0,
                    16'd0, 16'd0, 16'd0, 16'd0);
        send_fields(REQ_INSERT, 16'hFFFF, 16'hFFFF, 6'd0, 6'd0, 16'h7FFF,
                    16'd0, 16'd0, 16'd0, 16'd0);
        send_fields(REQ_INSERT, 16'd3, 16'd9, 6'd63, 6'd1, 16'd100,
                    16'd0, 16'd0, 16'd0, 16'd0);
        send_fields(REQ_LOOKUP, 16'hFFFF, 16'hFFFF, 6'd0, 6'd0, 16'd0,
                    16'd0, 16'd0, 16'd0, 16'd0);
        send_fields(REQ_LOOKUP, 16'd1, 16'd1, 6'd0, 6'd0, 16'd0,
                    16'd0, 16'd0, 16'd0, 16'd0);
        send_fields(REQ_COUNT, 16'd0, 16'd0, 6'd0, 6'd0, 16'd0,
                    16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        send_fields(REQ_COUNT, 16'd0, 16'd0, 6'd0, 6'd0, 16'd0,
                    16'hFFFF, 16'hFFFE, 16'hFFFF, 16'hFFFE);
        send_fields(REQ_COUNT, 16'd0, 16'd0, 6'd0, 6'd0, 16'd0,
                    16'd0, 16'd65, 16'd0, 16'd9);
        send_fields(REQ_NEXT, 16'd40, 16'd40, 6'd0, 6'd0, 16'd0,
                    16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        send_fields(REQ_NEXT, 16'd0, 16'd0, 6'd0, 6'd0, 16'd0,
                    16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        send_fields(REQ_NEXT, 16'd3, 16'd9, 6'd0, 6'd0, 16'd0,
                    16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        send_fields(REQ_NEXT, 16'd0, 16'd0, 6'd0, 6'd0, 16'd0,
                    16'd100, 16'd200, 16'd100, 16'd200);
        wait_drained();

        // Random phases, each with its own lengths; some phases also idle the handshakes.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: set_lengths(17'd65536, 17'd65536);
                1: set_lengths(17'd1, 17'd1);
                2: set_lengths(17'd0, 17'($urandom_range(65536, 1)));
                3: set_lengths(17'($urandom_range(65536, 1)), 17'd65536);
                default: set_lengths(17'd6, 17'd12);
            endcase
            send_idle_pct = idle_set[ph];
            recv_stall_pct = stall_set[ph];
            for (int n = 0; n < 220; n++)
                send_request(rand_request());
            wait_drained();
        end

        if (seed_sb.errors == 0)
            $display("seed_table_min_energy_tb passed");
        else
            $display("seed_table_min_energy_tb failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #10ms;
        $display("seed_table_min_energy_tb failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/stme_pkg.sv
rtl/seed_table_min_energy.sv
bench/seed_table_min_energy_tb.sv
